/* hdl/second_order_discrete_compensator_macros.svh */
// assertion helpers shared by the compensator rtl
`ifndef SECOND_ORDER_DISCRETE_COMPENSATOR_MACROS_SVH
`define SECOND_ORDER_DISCRETE_COMPENSATOR_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SODC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SODC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sodc_pkg.sv */
`default_nettype none

package sodc_pkg;

    // default widths of the signal and coefficient words
    localparam int SIGNAL_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF   = 24;

    // fraction bits of the coefficients, removed after the sum
    localparam int COEF_FRAC = 16;

    // register index port width
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SETPOINT    = 3'd0,
        REG_COEF_B0     = 3'd1,
        REG_COEF_B1     = 3'd2,
        REG_COEF_B2     = 3'd3,
        REG_COEF_A1     = 3'd4,
        REG_COEF_A2     = 3'd5,
        REG_UPPER_LIMIT = 3'd6
    } reg_index_t;

endpackage

`default_nettype wire

/* hdl/sodc_regs.sv */
`default_nettype none

module sodc_regs #(
    parameter int SIGNAL_WIDTH = sodc_pkg::SIGNAL_WIDTH_DEF,
    parameter int COEF_WIDTH   = sodc_pkg::COEF_WIDTH_DEF,
    parameter int CFG_DATA_W   = (SIGNAL_WIDTH > COEF_WIDTH) ? SIGNAL_WIDTH : COEF_WIDTH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [sodc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]               cfg_wdata,
    output logic signed [SIGNAL_WIDTH-1:0]           setpoint,
    output logic signed [COEF_WIDTH-1:0]             coef_b0,
    output logic signed [COEF_WIDTH-1:0]             coef_b1,
    output logic signed [COEF_WIDTH-1:0]             coef_b2,
    output logic signed [COEF_WIDTH-1:0]             coef_a1,
    output logic signed [COEF_WIDTH-1:0]             coef_a2,
    output logic [SIGNAL_WIDTH-2:0]                  upper_limit
);

    import sodc_pkg::*;

    // power-up gains of the controller
    localparam int SETPOINT_RST = 4096;
    localparam int COEF_B0_RST  = 282362;
    localparam int COEF_B1_RST  = -441049;
    localparam int COEF_B2_RST  = 193530;
    localparam int COEF_A1_RST  = -57035;
    localparam int COEF_A2_RST  = -8501;
    localparam int LIMIT_RST    = 13517;

    logic signed [SIGNAL_WIDTH-1:0] setpoint_reg;
    logic signed [COEF_WIDTH-1:0]   coef_b0_reg;
    logic signed [COEF_WIDTH-1:0]   coef_b1_reg;
    logic signed [COEF_WIDTH-1:0]   coef_b2_reg;
    logic signed [COEF_WIDTH-1:0]   coef_a1_reg;
    logic signed [COEF_WIDTH-1:0]   coef_a2_reg;
    logic [SIGNAL_WIDTH-2:0]        limit_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg <= SIGNAL_WIDTH'(SETPOINT_RST);
            coef_b0_reg  <= COEF_WIDTH'(COEF_B0_RST);
            coef_b1_reg  <= COEF_WIDTH'(COEF_B1_RST);
            coef_b2_reg  <= COEF_WIDTH'(COEF_B2_RST);
            coef_a1_reg  <= COEF_WIDTH'(COEF_A1_RST);
            coef_a2_reg  <= COEF_WIDTH'(COEF_A2_RST);
            limit_reg    <= (SIGNAL_WIDTH-1)'(LIMIT_RST);
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_index))
                REG_SETPOINT:    setpoint_reg <= cfg_wdata[SIGNAL_WIDTH-1:0];
                REG_COEF_B0:     coef_b0_reg  <= cfg_wdata[COEF_WIDTH-1:0];
                REG_COEF_B1:     coef_b1_reg  <= cfg_wdata[COEF_WIDTH-1:0];
                REG_COEF_B2:     coef_b2_reg  <= cfg_wdata[COEF_WIDTH-1:0];
                REG_COEF_A1:     coef_a1_reg  <= cfg_wdata[COEF_WIDTH-1:0];
                REG_COEF_A2:     coef_a2_reg  <= cfg_wdata[COEF_WIDTH-1:0];
                REG_UPPER_LIMIT: limit_reg    <= cfg_wdata[SIGNAL_WIDTH-2:0];
                default: ;
            endcase
        end
    end

    assign setpoint    = setpoint_reg;
    assign coef_b0     = coef_b0_reg;
    assign coef_b1     = coef_b1_reg;
    assign coef_b2     = coef_b2_reg;
    assign coef_a1     = coef_a1_reg;
    assign coef_a2     = coef_a2_reg;
    assign upper_limit = limit_reg;

endmodule

`default_nettype wire

/* hdl/sodc_arith.sv */
`default_nettype none

module sodc_arith #(
    parameter int SIGNAL_WIDTH = sodc_pkg::SIGNAL_WIDTH_DEF,
    parameter int COEF_WIDTH   = sodc_pkg::COEF_WIDTH_DEF
) (
    input  wire logic signed [SIGNAL_WIDTH-1:0] setpoint,
    input  wire logic signed [SIGNAL_WIDTH-1:0] measurement,
    input  wire logic signed [COEF_WIDTH-1:0]   coef_b0,
    input  wire logic signed [COEF_WIDTH-1:0]   coef_b1,
    input  wire logic signed [COEF_WIDTH-1:0]   coef_b2,
    input  wire logic signed [COEF_WIDTH-1:0]   coef_a1,
    input  wire logic signed [COEF_WIDTH-1:0]   coef_a2,
    input  wire logic [SIGNAL_WIDTH-2:0]        upper_limit,
    input  wire logic signed [SIGNAL_WIDTH:0]   err_d1,
    input  wire logic signed [SIGNAL_WIDTH:0]   err_d2,
    input  wire logic [SIGNAL_WIDTH-2:0]        drive_d1,
    input  wire logic [SIGNAL_WIDTH-2:0]        drive_d2,
    output logic signed [SIGNAL_WIDTH:0]        err,
    output logic [SIGNAL_WIDTH-2:0]             drive,
    output logic                                clipped
);

    import sodc_pkg::*;

    localparam int ERR_W   = SIGNAL_WIDTH + 1;
    localparam int PROD_W  = COEF_WIDTH + ERR_W;
    localparam int ACC_W   = PROD_W + 3;
    localparam int RAW_W   = ACC_W - COEF_FRAC;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC - 1);

    logic signed [PROD_W-1:0] prod_b0;
    logic signed [PROD_W-1:0] prod_b1;
    logic signed [PROD_W-1:0] prod_b2;
    logic signed [PROD_W-1:0] prod_a1;
    logic signed [PROD_W-1:0] prod_a2;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [RAW_W-1:0]  raw;
    logic signed [RAW_W-1:0]  limit_ext;
    logic                     over;

    // error against the target, one bit of growth
    assign err = ERR_W'(setpoint) - ERR_W'(measurement);

    // five parallel products, drive history is non-negative
    assign prod_b0 = coef_b0 * err;
    assign prod_b1 = coef_b1 * err_d1;
    assign prod_b2 = coef_b2 * err_d2;
    assign prod_a1 = coef_a1 * $signed({2'b00, drive_d1});
    assign prod_a2 = coef_a2 * $signed({2'b00, drive_d2});

    // wide sum, feedback terms subtracted
    assign acc = ACC_W'(prod_b0) + ACC_W'(prod_b1) + ACC_W'(prod_b2)
               - ACC_W'(prod_a1) - ACC_W'(prod_a2);

    // round half up then floor shift out the fraction
    assign acc_rnd = acc + ROUND_HALF;
    assign raw     = acc_rnd[ACC_W-1:COEF_FRAC];

    // clamp to zero..upper limit
    assign limit_ext = $signed(RAW_W'(upper_limit));
    assign over      = raw > limit_ext;

    always_comb begin
        if (over) begin
            drive   = upper_limit;
            clipped = 1'b1;
        end else if (raw[RAW_W-1]) begin
            drive   = '0;
            clipped = 1'b1;
        end else begin
            drive   = raw[SIGNAL_WIDTH-2:0];
            clipped = 1'b0;
        end
    end

endmodule

`default_nettype wire

/* hdl/second_order_discrete_compensator.sv */
// Second-order discrete compensator, direct form 1.
// Input channel s_*: one measured plant sample per request (signed Q3.12).
// Result channel m_*: one clamped drive per sample (Q3.12) with a clipped flag
// in m_tuser; results leave in the order the samples came in.
// Configuration: cfg_wr_en / cfg_index / cfg_wdata write setpoint, the five
// Q7.16 coefficients and the upper clamp; write only while no sample is in flight.
// Path: a sample taken into the input register is computed and lands in the
// result register once the result slot is free or draining; m_tvalid is high
// from then.
// Throughput: one sample per cycle while m_tready stays high. The error/drive
// history updates at the same edge that a result is registered, so the five
// multipliers, the sum and the clamp form one register-to-register path.
// Reset (aresetn low, synchronous): both stages empty, histories cleared,
// registers back to their power-up gains.
// Receiver stall: the result register holds, the input register keeps one more
// sample, then s_tready drops until m_tready returns; nothing is lost.
`default_nettype none

module second_order_discrete_compensator #(
    parameter int SIGNAL_WIDTH = sodc_pkg::SIGNAL_WIDTH_DEF,
    parameter int COEF_WIDTH   = sodc_pkg::COEF_WIDTH_DEF,
    localparam int S_TDATA_W   = ((SIGNAL_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W   = ((SIGNAL_WIDTH - 1 + 7) / 8) * 8,
    localparam int CFG_DATA_W  = (SIGNAL_WIDTH > COEF_WIDTH) ? SIGNAL_WIDTH : COEF_WIDTH
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input samples
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [S_TDATA_W-1:0]             s_tdata,   // measurement
    // results
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [M_TDATA_W-1:0]                  m_tdata,   // drive
    output logic                                  m_tuser,   // clipped
    // configuration writes
    input  wire logic                             cfg_wr_en,
    input  wire logic [sodc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]            cfg_wdata
);

    import sodc_pkg::*;

    `include "second_order_discrete_compensator_macros.svh"

    logic signed [SIGNAL_WIDTH-1:0] setpoint;
    logic signed [COEF_WIDTH-1:0]   coef_b0;
    logic signed [COEF_WIDTH-1:0]   coef_b1;
    logic signed [COEF_WIDTH-1:0]   coef_b2;
    logic signed [COEF_WIDTH-1:0]   coef_a1;
    logic signed [COEF_WIDTH-1:0]   coef_a2;
    logic [SIGNAL_WIDTH-2:0]        upper_limit;

    logic                           in_valid_reg;
    logic                           in_valid_next;
    logic signed [SIGNAL_WIDTH-1:0] meas_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [SIGNAL_WIDTH-2:0]        drive_out_reg;
    logic                           clip_out_reg;

    logic signed [SIGNAL_WIDTH:0]   err_d1_reg;
    logic signed [SIGNAL_WIDTH:0]   err_d2_reg;
    logic [SIGNAL_WIDTH-2:0]        drive_d1_reg;
    logic [SIGNAL_WIDTH-2:0]        drive_d2_reg;

    logic signed [SIGNAL_WIDTH:0]   err;
    logic [SIGNAL_WIDTH-2:0]        drive;
    logic                           clipped;
    logic                           s_accept;
    logic                           advance;

    // configuration registers
    sodc_regs #(
        .SIGNAL_WIDTH (SIGNAL_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .CFG_DATA_W   (CFG_DATA_W)
    ) u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .setpoint    (setpoint),
        .coef_b0     (coef_b0),
        .coef_b1     (coef_b1),
        .coef_b2     (coef_b2),
        .coef_a1     (coef_a1),
        .coef_a2     (coef_a2),
        .upper_limit (upper_limit)
    );

    // filter arithmetic between input and result registers
    sodc_arith #(
        .SIGNAL_WIDTH (SIGNAL_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_arith (
        .setpoint    (setpoint),
        .measurement (meas_reg),
        .coef_b0     (coef_b0),
        .coef_b1     (coef_b1),
        .coef_b2     (coef_b2),
        .coef_a1     (coef_a1),
        .coef_a2     (coef_a2),
        .upper_limit (upper_limit),
        .err_d1      (err_d1_reg),
        .err_d2      (err_d2_reg),
        .drive_d1    (drive_d1_reg),
        .drive_d2    (drive_d2_reg),
        .err         (err),
        .drive       (drive),
        .clipped     (clipped)
    );

    // handshake: a sample moves on when the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state and filter history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            err_d1_reg    <= '0;
            err_d2_reg    <= '0;
            drive_d1_reg  <= '0;
            drive_d2_reg  <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                err_d1_reg   <= err;
                err_d2_reg   <= err_d1_reg;
                drive_d1_reg <= drive;
                drive_d2_reg <= drive_d1_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            meas_reg <= s_tdata[SIGNAL_WIDTH-1:0];
        end
        if (advance) begin
            drive_out_reg <= drive;
            clip_out_reg  <= clipped;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(drive_out_reg);
    assign m_tuser  = clip_out_reg;

    // checks
    `SODC_ASSERT_SAME(a_ready_low_only_when_full, !s_tready, in_valid_reg && out_valid_reg && !m_tready, "input blocked without a stalled result")
    `SODC_ASSERT_NEXT(a_drive_history_matches, advance, out_valid_reg && (drive_d1_reg == drive_out_reg), "drive history out of step with result")
    `SODC_ASSERT_NEXT(a_error_history_shift, advance, err_d2_reg == $past(err_d1_reg), "error history did not shift")

endmodule

`default_nettype wire

/* tb/sodc_drive_checker.sv */
`timescale 1ns / 1ps

module sodc_drive_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // measurement
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // drive, then one pad bit
    input  logic        m_tuser,   // clipped
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata,
    output int          mismatch_count,
    output int          outstanding
);
    import sodc_pkg::*;

    typedef struct packed {
        logic [14:0] drive;
        logic        clipped;
    } drive_t;

    // shadow of the gain registers
    logic signed [15:0] setpoint;
    logic signed [23:0] gain_b0;
    logic signed [23:0] gain_b1;
    logic signed [23:0] gain_b2;
    logic signed [23:0] gain_a1;
    logic signed [23:0] gain_a2;
    logic        [14:0] upper_limit;

    // error and drive history, newest first
    logic signed [16:0] err_z1;
    logic signed [16:0] err_z2;
    logic        [14:0] drv_z1;
    logic        [14:0] drv_z2;

    drive_t expected_drives[$];

    task automatic flag_mismatch(input string msg);
        $display("%0t ns  drive check: %s", $time, msg);
        mismatch_count++;
    endtask

    // one step of the direct form 1 law; the wide products stay far below
    // the accumulator overflow bound at these widths
    function automatic drive_t predict_drive(input logic signed [15:0] meas);
        longint err;
        longint acc;
        longint rounded;
        drive_t res;
        err = longint'(setpoint) - longint'(meas);
        acc = longint'(gain_b0) * err
            + longint'(gain_b1) * longint'(err_z1)
            + longint'(gain_b2) * longint'(err_z2)
            - longint'(gain_a1) * longint'(drv_z1)
            - longint'(gain_a2) * longint'(drv_z2);
        // round half up, then floor shift
        rounded = (acc + 64'sd32768) >>> COEF_FRAC;
        if (rounded > longint'(upper_limit)) begin
            res.drive   = upper_limit;
            res.clipped = 1'b1;
        end else if (rounded < 0) begin
            res.drive   = '0;
            res.clipped = 1'b1;
        end else begin
            res.drive   = 15'(rounded);
            res.clipped = 1'b0;
        end
        err_z2 = err_z1;
        err_z1 = 17'(err);
        drv_z2 = drv_z1;
        drv_z1 = res.drive;
        return res;
    endfunction

    always @(posedge aclk) begin
        drive_t want;
        if (!aresetn) begin
            setpoint    = 16'sd4096;
            gain_b0     = 24'sd282362;
            gain_b1     = -24'sd441049;
            gain_b2     = 24'sd193530;
            gain_a1     = -24'sd57035;
            gain_a2     = -24'sd8501;
            upper_limit = 15'd13517;
            err_z1      = '0;
            err_z2      = '0;
            drv_z1      = '0;
            drv_z2      = '0;
            expected_drives.delete();
        end else begin
            // register writes, upper bits beyond each register dropped
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SETPOINT:    setpoint    = cfg_wdata[15:0];
                    REG_COEF_B0:     gain_b0     = cfg_wdata;
                    REG_COEF_B1:     gain_b1     = cfg_wdata;
                    REG_COEF_B2:     gain_b2     = cfg_wdata;
                    REG_COEF_A1:     gain_a1     = cfg_wdata;
                    REG_COEF_A2:     gain_a2     = cfg_wdata;
                    REG_UPPER_LIMIT: upper_limit = cfg_wdata[14:0];
                    default: ;
                endcase
            end

            // result side against the oldest expectation
            if (m_tvalid && m_tready) begin
                if (expected_drives.size() == 0) begin
                    flag_mismatch($sformatf("result with nothing pending: drive %0d clipped %0d",
                                            m_tdata[14:0], m_tuser));
                end else begin
                    want = expected_drives.pop_front();
                    if (m_tdata[14:0] !== want.drive)
                        flag_mismatch($sformatf("drive %0d, expected %0d",
                                                m_tdata[14:0], want.drive));
                    if (m_tuser !== want.clipped)
                        flag_mismatch($sformatf("clipped %0b, expected %0b (drive %0d)",
                                                m_tuser, want.clipped, want.drive));
                    if (m_tdata[15] !== 1'b0)
                        flag_mismatch("pad bit of m_tdata not zero");
                end
            end

            // request side feeds the predictor
            if (s_tvalid && s_tready)
                expected_drives.push_back(predict_drive(s_tdata));
        end
        outstanding <= expected_drives.size();
    end

endmodule

/* tb/tb_second_order_discrete_compensator.sv */
`timescale 1ns / 1ps

module tb_second_order_discrete_compensator;
    import sodc_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 80;
    localparam int PHASE_SAMPLES = 170;
    localparam int TIMEOUT_NS    = 3_000_000;

    // index with no register behind it, writes must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

    typedef struct {
        logic signed [15:0] setpoint;
        logic signed [23:0] b0;
        logic signed [23:0] b1;
        logic signed [23:0] b2;
        logic signed [23:0] a1;
        logic signed [23:0] a2;
        logic        [14:0] upper;
    } gains_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_wdata;

    int mismatch_count;
    int outstanding;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_requests = 0;

    always #(CLK_HALF) aclk = ~aclk;

    second_order_discrete_compensator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sodc_drive_checker checker_inst (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // power-up gains of the block
    function automatic gains_t default_gains();
        gains_t g;
        g.setpoint = 16'sd4096;
        g.b0       = 24'sd282362;
        g.b1       = -24'sd441049;
        g.b2       = 24'sd193530;
        g.a1       = -24'sd57035;
        g.a2       = -24'sd8501;
        g.upper    = 15'd13517;
        return g;
    endfunction

    // bounded keeps the loop roughly well behaved, otherwise anything goes
    function automatic gains_t random_gains(input bit bounded);
        gains_t g;
        if (bounded) begin
            g.setpoint = 16'(int'($urandom_range(0, 16384)) - 8192);
            g.b0       = 24'(int'($urandom_range(0, 524288)) - 262144);
            g.b1       = 24'(int'($urandom_range(0, 262144)) - 131072);
            g.b2       = 24'(int'($urandom_range(0, 262144)) - 131072);
            g.a1       = 24'(int'($urandom_range(0, 131072)) - 65536);
            g.a2       = 24'(int'($urandom_range(0, 65536)) - 32768);
        end else begin
            g.setpoint = 16'($urandom);
            g.b0       = 24'($urandom);
            g.b1       = 24'($urandom);
            g.b2       = 24'($urandom);
            g.a1       = 24'($urandom);
            g.a2       = 24'($urandom);
        end
        g.upper = 15'($urandom_range(0, 32767));
        return g;
    endfunction

    // mostly close to the target, now and then anywhere in range
    function automatic logic [15:0] pick_measurement(input logic signed [15:0] target);
        if ($urandom_range(9) < 7)
            return 16'(int'(target) + int'($urandom_range(0, 1023)) - 512);
        return 16'($urandom);
    endfunction

    // one request, with random idle cycles ahead of it
    task automatic send_sample(input logic [15:0] value);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering and let every pending result drain
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [23:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // all seven registers, junk above the narrow ones, then a stray index
    task automatic load_config(input gains_t g);
        put_reg(REG_SETPOINT,    {8'($urandom), g.setpoint});
        put_reg(REG_COEF_B0,     g.b0);
        put_reg(REG_COEF_B1,     g.b1);
        put_reg(REG_COEF_B2,     g.b2);
        put_reg(REG_COEF_A1,     g.a1);
        put_reg(REG_COEF_A2,     g.a2);
        put_reg(REG_UPPER_LIMIT, {9'($urandom), g.upper});
        put_reg(REG_SPARE,       24'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input gains_t g, input int idle, input int stall,
                             input bit squeeze);
        load_config(g);
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < PHASE_SAMPLES; i++) begin
            if (squeeze && i == PHASE_SAMPLES / 3)
                hold_requests++;
            send_sample(pick_measurement(g.setpoint));
        end
        settle();
    endtask

    // receiver: random stalls plus one long counted hold-off on demand
    initial begin
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_done) begin
                holds_done = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // stimulus and verdict
    initial begin
        gains_t g;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // power-up gains: range ends, error of zero, around the target
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'h0000);
        send_sample(16'h1000);
        send_sample(16'h0fff);
        send_sample(16'hffff);
        send_sample(16'h0001);
        settle();

        // unity gain, drive follows minus the measurement
        g = default_gains();
        g.setpoint = '0;
        g.b0 = 24'sd65536;
        g.b1 = '0;
        g.b2 = '0;
        g.a1 = '0;
        g.a2 = '0;
        g.upper = 15'd100;
        load_config(g);
        send_sample(16'hff9c);   // exactly at the upper clamp
        send_sample(16'hff9b);   // one above the clamp
        send_sample(16'h0000);   // exactly zero
        send_sample(16'h0001);   // just below zero
        send_sample(16'h8000);
        send_sample(16'h7fff);
        settle();

        // half gain, rounding of the half steps
        g.b0 = 24'sd32768;
        load_config(g);
        send_sample(16'hfffd);
        send_sample(16'h0003);
        send_sample(16'hffff);
        settle();

        // clamp of zero
        g.upper = '0;
        load_config(g);
        send_sample(16'h0000);
        send_sample(16'hfffb);
        send_sample(16'h0005);
        settle();

        // random phases over several gain settings and flow patterns
        run_phase(default_gains(), 0, 0, 1'b0);
        run_phase(random_gains(1'b1), 64, 0, 1'b0);
        run_phase(random_gains(1'b0), 0, 64, 1'b0);
        g.setpoint = 16'sh8000;
        g.b0 = 24'sh7fffff;
        g.b1 = 24'sh7fffff;
        g.b2 = 24'sh7fffff;
        g.a1 = 24'sh7fffff;
        g.a2 = 24'sh7fffff;
        g.upper = 15'h7fff;
        run_phase(g, 29, 29, 1'b0);
        g.setpoint = 16'sh7fff;
        g.b0 = 24'sh800000;
        g.b1 = 24'sh800000;
        g.b2 = 24'sh800000;
        g.a1 = 24'sh800000;
        g.a2 = 24'sh800000;
        g.upper = '0;
        run_phase(g, 64, 0, 1'b0);
        run_phase(random_gains(1'b1), 0, 0, 1'b1);
        run_phase(random_gains(1'b1), 0, 64, 1'b0);
        g = default_gains();
        g.setpoint = 16'(int'($urandom_range(0, 16384)) - 8192);
        run_phase(g, 29, 29, 1'b0);

        if (mismatch_count == 0 && outstanding == 0) begin
            $display("** second_order_discrete_compensator: PASSED **");
        end else begin
            $display("** second_order_discrete_compensator: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("** second_order_discrete_compensator: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/sodc_pkg.sv
hdl/sodc_regs.sv
hdl/sodc_arith.sv
hdl/second_order_discrete_compensator.sv
tb/sodc_drive_checker.sv
tb/tb_second_order_discrete_compensator.sv
